FILE: rtl/core/tph_pkg.sv
// shared types, constants and codes for the tcp passive handshake table
// no dependencies
`default_nettype none

package tph_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(SLOT_COUNT - 1);

    localparam logic [31:0] RST_SERVER_ADDR = 32'h0a00_0002;
    localparam logic [15:0] RST_SRV_PORT    = 16'd8080;
    localparam logic [15:0] RST_RX_WINDOW   = 16'hffff;

    localparam int FLAG_FIN_BIT = 0;
    localparam int FLAG_SYN_BIT = 1;
    localparam int FLAG_ACK_BIT = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = 144;

    typedef enum logic [2:0] {
        EV_DROP    = 3'd0,
        EV_SYNACK  = 3'd1,
        EV_FULL    = 3'd2,
        EV_UNKNOWN = 3'd3,
        EV_MATCH   = 3'd4
    } t_event;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SERVER_ADDR = 2'd0,
        CFG_SRV_PORT    = 2'd1,
        CFG_RX_WINDOW   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DONE
    } t_state;

    // first field in the highest bits
    typedef struct packed {
        logic [31:0] initial_sequence;
        logic [31:0] acknowledgment_number;
        logic [31:0] sequence_number;
        logic [7:0]  flag_bits;
        logic [15:0] target_port;
        logic [31:0] target_address;
        logic [15:0] peer_port;
        logic [31:0] peer_address;
    } t_item;

    typedef struct packed {
        logic [15:0] reply_port;
        logic [31:0] reply_address;
        logic [15:0] reply_window;
        logic [31:0] reply_acknowledgment;
        logic [31:0] reply_sequence;
        logic [5:0]  slot_index;
        logic        slot_closed;
        logic        became_established;
        t_event      event_code;
    } t_result;

    typedef struct packed {
        logic        established;
        logic [31:0] peer_address;
        logic [15:0] peer_port;
        logic [31:0] send_next;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic load;
        logic res_drop;
        logic scan_start;
        logic scan_step;
        logic claim;
        logic match;
        logic res_miss;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic addressed;
        logic cand_hit;
        logic cand_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/core/tph_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/tph_ctrl.sv
// sequencing state machine: decode, slot scan, result handoff
// depends on tph_pkg
`default_nettype none

module tph_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_syn_open,
    input  wire tph_pkg::t_status i_sts,
    output logic                 o_in_ready,
    output tph_pkg::t_cmd        o_cmd
);

    tph_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tph_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tph_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tph_pkg::S_DECODE;
                end
            end
            tph_pkg::S_DECODE: begin
                if (!i_sts.addressed) begin
                    o_cmd.res_drop = 1'b1;
                    n_state        = tph_pkg::S_DONE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = tph_pkg::S_SCAN;
                end
            end
            tph_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.cand_hit) begin
                    o_cmd.claim = i_syn_open;
                    o_cmd.match = !i_syn_open;
                    n_state     = tph_pkg::S_DONE;
                end else if (i_sts.cand_last) begin
                    o_cmd.res_miss = 1'b1;
                    n_state        = tph_pkg::S_DONE;
                end
            end
            tph_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = tph_pkg::S_IDLE;
                end
            end
            default: n_state = tph_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/tph_dp.sv
// datapath: config registers, segment register, slot table, scan and result logic
// depends on tph_pkg and tph_ram
`default_nettype none

module tph_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tph_pkg::t_cmd                i_cmd,
    output tph_pkg::t_status                  o_sts,
    output logic                              o_syn_open,
    input  wire logic [tph_pkg::IN_TDATA_W-1:0] i_in_data,
    input  wire logic                         i_cfg_valid,
    input  wire logic [tph_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [tph_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output tph_pkg::t_result                  o_out_data
);

    logic [31:0] r_srv_addr;
    logic [15:0] r_srv_port;
    logic [15:0] r_rx_window;

    tph_pkg::t_item   r_item;
    tph_pkg::t_result r_res;
    tph_pkg::t_result n_res;
    logic             r_out_valid;
    tph_pkg::t_result r_out;

    logic [tph_pkg::SLOT_COUNT-1:0] r_used;
    logic [tph_pkg::IDX_W-1:0]      r_cnt;
    logic                           r_run;
    logic [tph_pkg::IDX_W-1:0]      r_cmp_idx;
    logic                           r_cmp_vld;

    tph_pkg::t_entry w_rd;
    tph_pkg::t_entry w_wr;
    logic            w_wr_en;
    logic            w_peer_eq;
    logic            w_estab_now;
    logic            w_fin;

    assign o_syn_open = r_item.flag_bits[tph_pkg::FLAG_SYN_BIT]
                      && !r_item.flag_bits[tph_pkg::FLAG_ACK_BIT];
    assign w_fin      = r_item.flag_bits[tph_pkg::FLAG_FIN_BIT];
    assign w_peer_eq  = r_used[r_cmp_idx]
                      && w_rd.peer_address == r_item.peer_address
                      && w_rd.peer_port == r_item.peer_port;
    assign w_estab_now = r_item.flag_bits[tph_pkg::FLAG_ACK_BIT] && !w_rd.established
                       && r_item.acknowledgment_number == w_rd.send_next;

    assign o_sts.addressed = r_item.target_address == r_srv_addr
                           && r_item.target_port == r_srv_port;
    assign o_sts.cand_hit  = r_cmp_vld && (o_syn_open ? !r_used[r_cmp_idx] : w_peer_eq);
    assign o_sts.cand_last = r_cmp_vld && r_cmp_idx == tph_pkg::SLOT_LAST;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        w_wr_en = 1'b0;
        w_wr    = w_rd;
        if (i_cmd.claim) begin
            w_wr_en           = 1'b1;
            w_wr.established  = 1'b0;
            w_wr.peer_address = r_item.peer_address;
            w_wr.peer_port    = r_item.peer_port;
            w_wr.send_next    = r_item.initial_sequence + 32'd1;
        end else if (i_cmd.match) begin
            w_wr_en          = w_estab_now;
            w_wr.established = 1'b1;
        end
    end

    tph_ram #(
        .WIDTH (tph_pkg::ENTRY_W),
        .DEPTH (tph_pkg::SLOT_COUNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_cmp_idx),
        .i_wr_data (w_wr),
        .i_rd_addr (r_cnt),
        .o_rd_data (w_rd)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srv_addr  <= tph_pkg::RST_SERVER_ADDR;
            r_srv_port  <= tph_pkg::RST_SRV_PORT;
            r_rx_window <= tph_pkg::RST_RX_WINDOW;
        end else if (i_cfg_valid) begin
            unique case (tph_pkg::t_cfg_idx'(i_cfg_index))
                tph_pkg::CFG_SERVER_ADDR: r_srv_addr  <= i_cfg_data;
                tph_pkg::CFG_SRV_PORT:    r_srv_port  <= i_cfg_data[15:0];
                tph_pkg::CFG_RX_WINDOW:   r_rx_window <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // scan counter and slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_run     <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_run     <= 1'b1;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_vld <= r_run;
                if (r_run && r_cnt == tph_pkg::SLOT_LAST) begin
                    r_run <= 1'b0;
                end
            end
            if (i_cmd.claim) begin
                r_used[r_cmp_idx] <= 1'b1;
            end else if (i_cmd.match && w_fin) begin
                r_used[r_cmp_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_cnt <= '0;
        end else if (i_cmd.scan_step && r_run) begin
            r_cmp_idx <= r_cnt;
            r_cnt     <= r_cnt + 1'b1;
        end
    end

    // result of the current segment
    always_comb begin
        n_res = '0;
        if (i_cmd.res_drop) begin
            n_res.event_code = tph_pkg::EV_DROP;
        end else if (i_cmd.res_miss) begin
            n_res.event_code = o_syn_open ? tph_pkg::EV_FULL : tph_pkg::EV_UNKNOWN;
        end else if (i_cmd.claim) begin
            n_res.event_code           = tph_pkg::EV_SYNACK;
            n_res.slot_index           = 6'(r_cmp_idx);
            n_res.reply_sequence       = r_item.initial_sequence;
            n_res.reply_acknowledgment = r_item.sequence_number + 32'd1;
            n_res.reply_window         = r_rx_window;
            n_res.reply_address        = r_item.peer_address;
            n_res.reply_port           = r_item.peer_port;
        end else if (i_cmd.match) begin
            n_res.event_code         = tph_pkg::EV_MATCH;
            n_res.slot_index         = 6'(r_cmp_idx);
            n_res.became_established = w_estab_now;
            n_res.slot_closed        = w_fin;
        end
    end

    // segment and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= tph_pkg::t_item'(i_in_data);
        end
        if (i_cmd.res_drop || i_cmd.res_miss || i_cmd.claim || i_cmd.match) begin
            r_res <= n_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/tcp_passive_handshake_table_core.sv
// top level of the tcp passive handshake table
// depends on tph_pkg, tph_ctrl, tph_dp (and through it tph_ram)
//
// usage:
//   s_axis carries one parsed tcp segment per transaction; m_axis returns
//   exactly one result per segment, in order. the config channel (index,
//   data) writes server address (0), server port (1) and receive window (2);
//   it is always ready, other indexes are ignored.
// flow:
//   a segment not sent to the server address and port is answered without
//   a table scan. otherwise the slot table (64 entries, one ram read
//   port) is walked one slot per cycle, lowest first, up to the first hit;
//   a full table or unknown peer is answered after the last slot.
//   s_axis_tready is high only between items, so one segment is in work
//   at a time.
// reset:
//   all slots free, config registers at their defaults, no result pending.
// stall:
//   a finished result waits in the output register while m_axis_tready is
//   low; the next segment may be accepted and worked on meanwhile, and its
//   result waits in the done state until the output register drains.
`default_nettype none

module tcp_passive_handshake_table_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // peer_address, peer_port, target_address, target_port, flag_bits,
    // sequence_number, acknowledgment_number, initial_sequence
    input  wire logic [tph_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // event_code, became_established, slot_closed, slot_index, reply_sequence,
    // reply_acknowledgment, reply_window, reply_address, reply_port, zero pad
    output logic [tph_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tph_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [tph_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    tph_pkg::t_cmd    w_cmd;
    tph_pkg::t_status w_sts;
    tph_pkg::t_result w_out;
    logic             w_syn_open;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = tph_pkg::OUT_TDATA_W'(w_out);

    tph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_syn_open (w_syn_open),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    tph_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_syn_open  (w_syn_open),
        .i_in_data   (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (w_out)
    );

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("segment accepted while another is in work");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded over a pending result");

    a_claim_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.claim || w_cmd.match) |-> w_sts.cand_hit)
        else $error("slot update without a scan hit");
`endif

endmodule

`default_nettype wire

FILE: test/tcp_passive_handshake_table_core_tb.sv
// testbench for tcp_passive_handshake_table_core: drives parsed segments and config writes,
// predicts every reply from its own slot table and checks each m_axis transaction field by field
// depends on tph_pkg and the rtl of the block
`timescale 1ns / 100ps

module tcp_passive_handshake_table_core_tb;

    import tph_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 600;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam logic [7:0] F_FIN = 8'h01 << FLAG_FIN_BIT;
    localparam logic [7:0] F_SYN = 8'h01 << FLAG_SYN_BIT;
    localparam logic [7:0] F_ACK = 8'h01 << FLAG_ACK_BIT;

    class slot_table_checker;
        logic [31:0] server_addr;
        logic [15:0] srv_port;
        logic [15:0] rx_window;
        bit          slot_used [SLOT_COUNT];
        bit          slot_estab [SLOT_COUNT];
        logic [31:0] slot_addr [SLOT_COUNT];
        logic [15:0] slot_port [SLOT_COUNT];
        logic [31:0] slot_snd_nxt [SLOT_COUNT];
        t_result     expected_replies [$];
        int          mismatch_count;

        function new();
            server_addr = RST_SERVER_ADDR;
            srv_port = RST_SRV_PORT;
            rx_window = RST_RX_WINDOW;
            mismatch_count = 0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_used[i] = 1'b0;
                slot_estab[i] = 1'b0;
            end
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SERVER_ADDR: server_addr = data;
                CFG_SRV_PORT: srv_port = data[15:0];
                CFG_RX_WINDOW: rx_window = data[15:0];
                default: ;
            endcase
        endfunction

        function void note_segment(t_item seg);
            t_result r;
            int hit;
            bit opening;
            r = '0;
            r.event_code = EV_DROP;
            hit = -1;
            opening = seg.flag_bits[FLAG_SYN_BIT] && !seg.flag_bits[FLAG_ACK_BIT];
            if (seg.target_address != server_addr || seg.target_port != srv_port) begin
                r.event_code = EV_DROP;
            end else if (opening) begin
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (hit < 0 && !slot_used[i]) hit = i;
                if (hit < 0) begin
                    r.event_code = EV_FULL;
                end else begin
                    slot_used[hit] = 1'b1;
                    slot_estab[hit] = 1'b0;
                    slot_addr[hit] = seg.peer_address;
                    slot_port[hit] = seg.peer_port;
                    slot_snd_nxt[hit] = seg.initial_sequence + 32'd1;
                    r.event_code = EV_SYNACK;
                    r.slot_index = 6'(hit);
                    r.reply_sequence = seg.initial_sequence;
                    r.reply_acknowledgment = seg.sequence_number + 32'd1;
                    r.reply_window = rx_window;
                    r.reply_address = seg.peer_address;
                    r.reply_port = seg.peer_port;
                end
            end else begin
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (hit < 0 && slot_used[i] && slot_addr[i] == seg.peer_address &&
                        slot_port[i] == seg.peer_port) hit = i;
                if (hit < 0) begin
                    r.event_code = EV_UNKNOWN;
                end else begin
                    r.event_code = EV_MATCH;
                    r.slot_index = 6'(hit);
                    if (seg.flag_bits[FLAG_ACK_BIT] && !slot_estab[hit] &&
                        seg.acknowledgment_number == slot_snd_nxt[hit]) begin
                        slot_estab[hit] = 1'b1;
                        r.became_established = 1'b1;
                    end
                    if (seg.flag_bits[FLAG_FIN_BIT]) begin
                        slot_used[hit] = 1'b0;
                        r.slot_closed = 1'b1;
                    end
                end
            end
            expected_replies.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("error at %0t ns: %s got %h expected %h", $realtime, what, got, want);
            mismatch_count++;
        endtask

        task check_field(string what, logic [31:0] got, logic [31:0] want);
            if (got !== want) report_mismatch(what, got, want);
        endtask

        task check_reply(logic [OUT_TDATA_W-1:0] raw);
            t_result got;
            t_result want;
            got = t_result'(raw[$bits(t_result)-1:0]);
            if (expected_replies.size() == 0) begin
                report_mismatch("reply with nothing outstanding", raw[31:0], '0);
            end else begin
                want = expected_replies.pop_front();
                check_field("event_code", got.event_code, want.event_code);
                check_field("became_established", got.became_established,
                            want.became_established);
                check_field("slot_closed", got.slot_closed, want.slot_closed);
                check_field("slot_index", got.slot_index, want.slot_index);
                check_field("reply_sequence", got.reply_sequence, want.reply_sequence);
                check_field("reply_acknowledgment", got.reply_acknowledgment,
                            want.reply_acknowledgment);
                check_field("reply_window", got.reply_window, want.reply_window);
                check_field("reply_address", got.reply_address, want.reply_address);
                check_field("reply_port", got.reply_port, want.reply_port);
                check_field("zero pad", raw[OUT_TDATA_W-1:$bits(t_result)], '0);
            end
        endtask

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    slot_table_checker table_sb = new();
    bit                steady = 1'b0;
    bit                drain_hold = 1'b0;
    logic [31:0]       pool_addr [8];
    logic [15:0]       pool_port [8];
    int unsigned       cycle_count = 0;

    tcp_passive_handshake_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // reply side: random stalls, steady stretches and one long hold-off
    initial begin
        int stall;
        int roll;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (drain_hold) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                drain_hold = 1'b0;
            end else if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                roll = $urandom_range(0, 99);
                if (steady || roll < 70) begin
                    m_axis_tready <= 1'b1;
                end else if (roll < 95) begin
                    m_axis_tready <= 1'b0;
                    stall = $urandom_range(0, 2);
                end else begin
                    m_axis_tready <= 1'b0;
                    stall = $urandom_range(20, 80);
                end
            end
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) table_sb.check_reply(m_axis_tdata);

    task automatic push_segment(input t_item seg);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55) gap = 0;
        else if (roll < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 60);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tdata <= seg;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        table_sb.note_segment(seg);
    endtask

    task automatic send_fixed(input logic [31:0] paddr, input logic [15:0] pport,
                              input logic [31:0] taddr, input logic [15:0] tport,
                              input logic [7:0] flags, input logic [31:0] seqn,
                              input logic [31:0] ackn, input logic [31:0] isn);
        t_item seg;
        seg.peer_address = paddr;
        seg.peer_port = pport;
        seg.target_address = taddr;
        seg.target_port = tport;
        seg.flag_bits = flags;
        seg.sequence_number = seqn;
        seg.acknowledgment_number = ackn;
        seg.initial_sequence = isn;
        push_segment(seg);
    endtask

    // handshakes on live slots, opens (share set by syn_pct), misaddressed and stray segments
    task automatic make_segment(input int syn_pct, output t_item seg);
        int roll;
        int j;
        int live [$];
        if ($urandom_range(0, 4) != 0) begin
            j = $urandom_range(0, 7);
            seg.peer_address = pool_addr[j];
            seg.peer_port = pool_port[j];
        end else begin
            seg.peer_address = $urandom;
            seg.peer_port = 16'($urandom);
        end
        seg.target_address = table_sb.server_addr;
        seg.target_port = table_sb.srv_port;
        seg.flag_bits = 8'($urandom);
        seg.sequence_number = $urandom;
        seg.acknowledgment_number = $urandom;
        seg.initial_sequence = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            case ($urandom_range(0, 2))
                0: seg.target_address ^= 32'h1 << $urandom_range(0, 31);
                1: seg.target_port = 16'($urandom);
                default: seg.target_address = $urandom;
            endcase
        end else if (roll < 8 + syn_pct) begin
            seg.flag_bits[FLAG_SYN_BIT] = 1'b1;
            seg.flag_bits[FLAG_ACK_BIT] = 1'b0;
        end else begin
            for (int i = 0; i < SLOT_COUNT; i++)
                if (table_sb.slot_used[i]) live.push_back(i);
            if (live.size() != 0 && roll < 90) begin
                j = live[$urandom_range(0, live.size() - 1)];
                seg.peer_address = table_sb.slot_addr[j];
                seg.peer_port = table_sb.slot_port[j];
                if ($urandom_range(0, 99) < 65) begin
                    seg.flag_bits[FLAG_ACK_BIT] = 1'b1;
                    if ($urandom_range(0, 4) != 0) seg.flag_bits[FLAG_FIN_BIT] = 1'b0;
                    if ($urandom_range(0, 4) != 0)
                        seg.acknowledgment_number = table_sb.slot_snd_nxt[j];
                end else begin
                    seg.flag_bits[FLAG_FIN_BIT] = 1'b1;
                end
            end
        end
    endtask

    task automatic run_burst(input int count, input int syn_pct, input int hold_at);
        t_item seg;
        for (int i = 0; i < 8; i++) begin
            pool_addr[i] = $urandom;
            pool_port[i] = 16'($urandom);
        end
        for (int k = 0; k < count; k++) begin
            if (k == hold_at) drain_hold = 1'b1;
            steady = ((k / 40) % 4 == 3);
            make_segment(syn_pct, seg);
            push_segment(seg);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (table_sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        table_sb.write_reg(idx, data);
    endtask

    task automatic configure(input logic [31:0] addr, input logic [15:0] port,
                             input logic [15:0] win, input bit poke_unused);
        write_cfg(CFG_SERVER_ADDR, addr);
        write_cfg(CFG_SRV_PORT, {16'($urandom), port});
        write_cfg(CFG_RX_WINDOW, {16'($urandom), win});
        if (poke_unused) write_cfg(CFG_UNUSED_IDX, $urandom);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] a;
        logic [15:0] p;
        a = RST_SERVER_ADDR;
        p = RST_SRV_PORT;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // misaddressed, open with wrapping numbers, ack states, duplicate open, close
        send_fixed('0, '0, a ^ 32'h1, p, F_SYN, '0, '0, '0);
        send_fixed('0, '0, a, p + 16'd1, F_SYN, '0, '0, '0);
        send_fixed('1, '1, a, p, F_SYN, 32'hffff_ffff, '0, 32'hffff_ffff);
        send_fixed('1, '1, a, p, F_ACK, '0, 32'h1, '0);
        send_fixed('1, '1, a, p, F_ACK, '0, '0, '0);
        send_fixed('1, '1, a, p, F_ACK, '0, '0, '0);
        send_fixed('1, '1, a, p, F_SYN, 32'h55aa, '0, 32'h1234_5677);
        send_fixed('0, '0, a, p, F_SYN | F_ACK, '0, '0, '0);
        send_fixed('1, '1, a, p, 8'h00, '0, '0, '0);
        send_fixed('1, '1, a, p, F_FIN | F_ACK, '0, '0, '0);
        send_fixed('1, '1, a, p, F_FIN | F_ACK, '0, 32'h1234_5678, '0);
        send_fixed('0, '0, a, p, 8'hff & ~F_ACK, '0, '0, '0);
        send_fixed('0, '0, a, p, 8'hff, '0, 32'h1, '0);
        send_fixed('0, '0, a, p, F_ACK, '0, '0, '0);

        run_burst(120, 30, -1);
        settle();
        configure('0, '0, '0, 1'b0);
        run_burst(150, 30, -1);
        settle();
        configure('1, '1, '1, 1'b1);
        run_burst(180, 70, 60);
        settle();
        configure($urandom, 16'($urandom), 16'($urandom), 1'b0);
        run_burst(150, 15, -1);
        settle();
        configure($urandom, 16'($urandom), 16'($urandom), 1'b1);
        run_burst(150, 35, -1);
        settle();
        configure($urandom, RST_SRV_PORT, 16'($urandom), 1'b0);
        run_burst(150, 30, -1);
        settle();
        repeat (80) @(posedge i_clk);

        if (table_sb.mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
